### hw/rtl/bme_pkg.sv
// Shared types and constants of the byte machine instruction execute block.
// Holds the item structs, command, opcode, status and register index codes.
// No dependencies; every other file of the block but bme_ram imports this package.
package bme_pkg;

   // Program space length; pc + 1 wraps at this bound.
   localparam int unsigned PROGRAM_WORDS = 1024;

   // Configuration registers.
   localparam int unsigned CSR_DATA_W = 10;
   localparam logic [0:0] CSR_REG_COUNT = 1'b0;
   localparam logic [0:0] CSR_RAM_SIZE  = 1'b1;
   localparam logic [5:0] REG_COUNT_RESET = 6'd32;
   localparam logic [9:0] RAM_SIZE_RESET  = 10'd512;

   // Command codes; codes above CMD_READ_RAM are unknown.
   localparam logic [2:0] CMD_EXEC     = 3'd0;
   localparam logic [2:0] CMD_LOAD_REG = 3'd1;
   localparam logic [2:0] CMD_LOAD_RAM = 3'd2;
   localparam logic [2:0] CMD_READ_REG = 3'd3;
   localparam logic [2:0] CMD_READ_RAM = 3'd4;

   // Opcodes; anything above OP_STOREI is unknown.
   localparam logic [7:0] OP_AND    = 8'd0;
   localparam logic [7:0] OP_OR     = 8'd1;
   localparam logic [7:0] OP_ADD    = 8'd2;
   localparam logic [7:0] OP_MUL    = 8'd3;
   localparam logic [7:0] OP_XOR    = 8'd4;
   localparam logic [7:0] OP_PRINT  = 8'd5;
   localparam logic [7:0] OP_SLEEP  = 8'd6;
   localparam logic [7:0] OP_LOAD   = 8'd7;
   localparam logic [7:0] OP_STORE  = 8'd8;
   localparam logic [7:0] OP_JNE    = 8'd9;
   localparam logic [7:0] OP_LOADI  = 8'd10;
   localparam logic [7:0] OP_STOREI = 8'd11;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BAD_OP = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   // One input item.
   typedef struct packed {
      logic [2:0] command;
      logic [7:0] opcode;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [7:0] operand_c;
      logic [8:0] load_address;
      logic [7:0] load_data;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [9:0] next_pc;
      logic       print_valid;
      logic [7:0] print_byte;
      logic       sleep_valid;
      logic [7:0] sleep_seconds;
      logic [7:0] read_data;
      logic [1:0] status;
   } rsp_type;

   // Decoded item, from the accept stage to the execute stage.
   typedef struct packed {
      req_type    req;
      logic [1:0] status;
      logic       rd_x;
      logic [8:0] x_idx;
      logic       rd_y;
      logic [8:0] y_idx;
      logic       wr_reg;
      logic [8:0] w_idx;
   } dec_type;

   // Executed item, from the execute stage to the writeback stage.
   typedef struct packed {
      rsp_type    rsp;
      logic       reg_we;
      logic       reg_from_mem;
      logic [8:0] reg_widx;
      logic [7:0] reg_wdata;
      logic       mem_we;
      logic       mem_to_rsp;
      logic [8:0] mem_addr;
      logic [7:0] mem_wdata;
   } exe_type;

endpackage

### hw/rtl/bme_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read.
// Depends on nothing; used for the register file banks and the data memory.
module bme_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/bme_decode.sv
// Accept-stage decode: range checks, register read ports and write target.
// Depends on bme_pkg.
module bme_decode
   import bme_pkg::*;
#(
   parameter int unsigned REGISTERS    = 32,
   parameter int unsigned MEMORY_BYTES = 512
) (
   input  req_type    req,
   input  logic [5:0] reg_count,
   input  logic [9:0] ram_size,
   output dec_type    dec
);

   localparam logic [12:0] RegMax = 13'(REGISTERS);
   localparam logic [12:0] MemMax = 13'(MEMORY_BYTES);

   function automatic logic reg_ok(input logic [8:0] idx, input logic [5:0] count);
      reg_ok = ({3'b000, count} > idx) && (13'(idx) < RegMax);
   endfunction

   function automatic logic ram_ok(input logic [8:0] adr, input logic [9:0] size);
      ram_ok = (size > {1'b0, adr}) && (13'(adr) < MemMax);
   endfunction

   logic [8:0] a_idx;
   logic [8:0] b_idx;
   logic [8:0] c_idx;
   logic       alu_op;
   logic       need_b;
   logic       need_c;
   logic       ok;

   assign a_idx = {1'b0, req.operand_a};
   assign b_idx = {1'b0, req.operand_b};
   assign c_idx = {1'b0, req.operand_c};

   // Status from opcode, command, every register index the item uses and the RAM address of a RAM command.
   always_comb begin
      alu_op = (req.opcode <= OP_XOR);
      need_c = alu_op;
      need_b = alu_op || (req.opcode == OP_LOAD) || (req.opcode == OP_STORE) ||
               (req.opcode == OP_JNE);
      dec.status = ST_OK;
      unique case (req.command)
         CMD_EXEC: begin
            if (req.opcode > OP_STOREI) begin
               dec.status = ST_BAD_OP;
            end else if (!reg_ok(a_idx, reg_count) ||
                         (need_b && !reg_ok(b_idx, reg_count)) ||
                         (need_c && !reg_ok(c_idx, reg_count))) begin
               dec.status = ST_RANGE;
            end
         end
         CMD_LOAD_REG, CMD_READ_REG: begin
            if (!reg_ok(req.load_address, reg_count)) begin
               dec.status = ST_RANGE;
            end
         end
         CMD_LOAD_RAM, CMD_READ_RAM: begin
            if (!ram_ok(req.load_address, ram_size)) begin
               dec.status = ST_RANGE;
            end
         end
         default: begin
            dec.status = ST_BAD_OP;
         end
      endcase
      ok = (dec.status == ST_OK);

      // Port X carries operand b (or the read address), port Y operand c or a.
      dec.req   = req;
      dec.x_idx = (req.command == CMD_READ_REG) ? req.load_address : b_idx;
      dec.y_idx = alu_op ? c_idx : a_idx;
      dec.rd_x  = ok && (((req.command == CMD_EXEC) && need_b) ||
                         (req.command == CMD_READ_REG));
      dec.rd_y  = ok && (req.command == CMD_EXEC) && (req.opcode != OP_LOAD) &&
                  (req.opcode != OP_LOADI);

      // Register that this item may write; a later LOAD fault only drops it.
      dec.w_idx  = (req.command == CMD_EXEC) ? a_idx : req.load_address;
      dec.wr_reg = ok && (((req.command == CMD_EXEC) &&
                           (alu_op || (req.opcode == OP_LOAD) ||
                            (req.opcode == OP_LOADI))) ||
                          (req.command == CMD_LOAD_REG));
   end

endmodule

### hw/rtl/bme_execute.sv
// Execute stage: ALU, jump, RAM address checks and the result fields.
// Depends on bme_pkg; register operands arrive from the register file banks.
module bme_execute
   import bme_pkg::*;
#(
   parameter int unsigned MEMORY_BYTES = 512
) (
   input  dec_type    dec,
   input  logic [7:0] x_data,
   input  logic [7:0] y_data,
   input  logic [9:0] pc,
   input  logic [9:0] ram_size,
   output exe_type    exe
);

   localparam logic [12:0] MemMax = 13'(MEMORY_BYTES);
   localparam logic [12:0] PcWrap = 13'(PROGRAM_WORDS);

   function automatic logic ram_ok(input logic [8:0] adr, input logic [9:0] size);
      ram_ok = (size > {1'b0, adr}) && (13'(adr) < MemMax);
   endfunction

   logic [12:0] pc_inc;
   logic [9:0]  pc_next;
   logic [15:0] product;
   logic [8:0]  x_addr;
   logic [8:0]  y_addr;

   // Sequential pc; pc stays below the wrap bound, so one subtract is enough.
   always_comb begin
      pc_inc = 13'(pc) + 13'd1;
      if (pc_inc >= PcWrap) begin
         pc_inc = pc_inc - PcWrap;
      end
      pc_next = pc_inc[9:0];
   end

   assign product = 16'(x_data) * 16'(y_data);
   assign x_addr  = {1'b0, x_data};
   assign y_addr  = {1'b0, y_data};

   // Instruction and command effects.
   always_comb begin
      exe              = '0;
      exe.rsp.status   = dec.status;
      exe.rsp.next_pc  = pc;
      exe.reg_widx     = dec.w_idx;
      exe.mem_addr     = dec.req.load_address;
      exe.mem_wdata    = dec.req.load_data;
      if (dec.status == ST_OK) begin
         unique case (dec.req.command)
            CMD_EXEC: begin
               exe.rsp.next_pc = pc_next;
               unique case (dec.req.opcode)
                  OP_AND: begin
                     exe.reg_we    = 1'b1;
                     exe.reg_wdata = x_data & y_data;
                  end
                  OP_OR: begin
                     exe.reg_we    = 1'b1;
                     exe.reg_wdata = x_data | y_data;
                  end
                  OP_ADD: begin
                     exe.reg_we    = 1'b1;
                     exe.reg_wdata = x_data + y_data;
                  end
                  OP_MUL: begin
                     exe.reg_we    = 1'b1;
                     exe.reg_wdata = product[7:0];
                  end
                  OP_XOR: begin
                     exe.reg_we    = 1'b1;
                     exe.reg_wdata = x_data ^ y_data;
                  end
                  OP_PRINT: begin
                     exe.rsp.print_valid = 1'b1;
                     exe.rsp.print_byte  = y_data;
                  end
                  OP_SLEEP: begin
                     exe.rsp.sleep_valid   = 1'b1;
                     exe.rsp.sleep_seconds = y_data;
                  end
                  OP_LOAD: begin
                     exe.mem_addr = x_addr;
                     if (ram_ok(x_addr, ram_size)) begin
                        exe.reg_we       = 1'b1;
                        exe.reg_from_mem = 1'b1;
                     end else begin
                        exe.rsp.status  = ST_RANGE;
                        exe.rsp.next_pc = pc;
                     end
                  end
                  OP_STORE: begin
                     exe.mem_addr  = x_addr;
                     exe.mem_wdata = y_data;
                     if (ram_ok(x_addr, ram_size)) begin
                        exe.mem_we = 1'b1;
                     end else begin
                        exe.rsp.status  = ST_RANGE;
                        exe.rsp.next_pc = pc;
                     end
                  end
                  OP_JNE: begin
                     if (y_data != x_data) begin
                        exe.rsp.next_pc = {2'b00, dec.req.operand_c};
                     end
                  end
                  OP_LOADI: begin
                     exe.reg_we    = 1'b1;
                     exe.reg_wdata = dec.req.operand_b;
                  end
                  OP_STOREI: begin
                     exe.mem_addr  = y_addr;
                     exe.mem_wdata = dec.req.operand_b;
                     if (ram_ok(y_addr, ram_size)) begin
                        exe.mem_we = 1'b1;
                     end else begin
                        exe.rsp.status  = ST_RANGE;
                        exe.rsp.next_pc = pc;
                     end
                  end
                  default: begin
                     exe.rsp.next_pc = pc;
                  end
               endcase
            end
            CMD_LOAD_REG: begin
               exe.reg_we    = 1'b1;
               exe.reg_wdata = dec.req.load_data;
            end
            CMD_LOAD_RAM: begin
               exe.mem_we = 1'b1;
            end
            CMD_READ_REG: begin
               exe.rsp.read_data = x_data;
            end
            CMD_READ_RAM: begin
               exe.mem_to_rsp = 1'b1;
            end
            default: begin
               exe.rsp.status = ST_BAD_OP;
            end
         endcase
      end
   end

endmodule

### hw/rtl/byte_machine_instruction_execute.sv
// Top level of the byte machine instruction execute block.
// Depends on bme_pkg, bme_ram, bme_decode and bme_execute.
//
//   Channel   Ports                              Moves
//   request   req_valid, req_ready, req_data     one command or instruction item
//   response  rsp_valid, rsp_ready, rsp_data     one result item per request item
//   csr       csr_we, csr_index, csr_wdata       register count and RAM size
//
// An item is accepted and reads the register file, executes and touches the
// data memory in stage one, and writes the register file and the output register
// in stage two. Independent items enter one per cycle while the response side
// does not stall. An item that reads a register that an item still in flight
// writes waits for that write, which sets the rate of dependent code. Reset
// clears pc and the pipeline valids and loads the configuration reset values;
// the memories need no clearing. A stalled response holds the later stages, and
// the request side takes items while stage one is free and no hazard is pending.
module byte_machine_instruction_execute
   import bme_pkg::*;
#(
   parameter int unsigned REGISTERS    = 32,
   parameter int unsigned MEMORY_BYTES = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned RIDX = (REGISTERS > 1) ? $clog2(REGISTERS) : 1;
   localparam int unsigned MIDX = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;

   logic [5:0] reg_count_ff, reg_count_in;
   logic [9:0] ram_size_ff, ram_size_in;
   logic [9:0] pc_ff, pc_in;

   logic    s1_valid_ff, s1_valid_in;
   dec_type s1_dec_ff, s1_dec_in;
   logic    s2_valid_ff, s2_valid_in;
   exe_type s2_exe_ff, s2_exe_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   dec_type     dec;
   exe_type     exe;
   logic [7:0]  x_data;
   logic [7:0]  y_data;
   logic [7:0]  mem_rdata;
   logic [7:0]  reg_wdata;
   logic [12:0] mem_addr_wide;
   logic        hazard;
   logic        accept;
   logic        out_free;
   logic        s2_move;
   logic        s2_free;
   logic        s1_move;
   logic        s1_free;

   // Decode of the item offered on the request channel.
   bme_decode #(
      .REGISTERS    (REGISTERS),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_decode (
      .req       (req_data),
      .reg_count (reg_count_ff),
      .ram_size  (ram_size_ff),
      .dec       (dec)
   );

   // A register read must not overtake a pending write of the same register.
   always_comb begin
      hazard = 1'b0;
      if (s1_valid_ff && s1_dec_ff.wr_reg) begin
         hazard = (dec.rd_x && (dec.x_idx == s1_dec_ff.w_idx)) ||
                  (dec.rd_y && (dec.y_idx == s1_dec_ff.w_idx));
      end
      if (s2_valid_ff && s2_exe_ff.reg_we) begin
         hazard = hazard || (dec.rd_x && (dec.x_idx == s2_exe_ff.reg_widx)) ||
                  (dec.rd_y && (dec.y_idx == s2_exe_ff.reg_widx));
      end
   end

   // Stage flow control.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free && !hazard;
   assign accept    = req_valid && req_ready;

   // Register file: two banks written alike, one read port each.
   assign reg_wdata = s2_exe_ff.reg_from_mem ? mem_rdata : s2_exe_ff.reg_wdata;

   bme_ram #(
      .WIDTH (8),
      .DEPTH (REGISTERS)
   ) u_reg_bank_x (
      .clock (clock),
      .we    (s2_move && s2_exe_ff.reg_we),
      .waddr (s2_exe_ff.reg_widx[RIDX-1:0]),
      .wdata (reg_wdata),
      .re    (accept),
      .raddr (dec.x_idx[RIDX-1:0]),
      .rdata (x_data)
   );

   bme_ram #(
      .WIDTH (8),
      .DEPTH (REGISTERS)
   ) u_reg_bank_y (
      .clock (clock),
      .we    (s2_move && s2_exe_ff.reg_we),
      .waddr (s2_exe_ff.reg_widx[RIDX-1:0]),
      .wdata (reg_wdata),
      .re    (accept),
      .raddr (dec.y_idx[RIDX-1:0]),
      .rdata (y_data)
   );

   // Execute stage.
   bme_execute #(
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_execute (
      .dec      (s1_dec_ff),
      .x_data   (x_data),
      .y_data   (y_data),
      .pc       (pc_ff),
      .ram_size (ram_size_ff),
      .exe      (exe)
   );

   // Data memory: written and read by the item leaving the execute stage.
   assign mem_addr_wide = 13'(exe.mem_addr);

   bme_ram #(
      .WIDTH (8),
      .DEPTH (MEMORY_BYTES)
   ) u_data_mem (
      .clock (clock),
      .we    (s1_move && exe.mem_we),
      .waddr (mem_addr_wide[MIDX-1:0]),
      .wdata (exe.mem_wdata),
      .re    (s1_move),
      .raddr (mem_addr_wide[MIDX-1:0]),
      .rdata (mem_rdata)
   );

   // Next values of configuration, pc and pipeline control.
   always_comb begin
      reg_count_in = reg_count_ff;
      ram_size_in  = ram_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_REG_COUNT: reg_count_in = csr_wdata[5:0];
            CSR_RAM_SIZE:  ram_size_in  = csr_wdata;
            default:       ram_size_in  = ram_size_ff;
         endcase
      end
      pc_in        = s1_move ? exe.rsp.next_pc : pc_ff;
      s1_valid_in  = accept || (s1_valid_ff && !s2_free);
      s2_valid_in  = s1_move || (s2_valid_ff && !out_free);
      rsp_valid_in = s2_move || (rsp_valid_ff && !rsp_ready);
   end

   // Next values of the stage payloads.
   always_comb begin
      s1_dec_in   = accept ? dec : s1_dec_ff;
      s2_exe_in   = s1_move ? exe : s2_exe_ff;
      rsp_data_in = rsp_data_ff;
      if (s2_move) begin
         rsp_data_in = s2_exe_ff.rsp;
         if (s2_exe_ff.mem_to_rsp) begin
            rsp_data_in.read_data = mem_rdata;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_count_ff <= REG_COUNT_RESET;
         ram_size_ff  <= RAM_SIZE_RESET;
         pc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reg_count_ff <= reg_count_in;
         ram_size_ff  <= ram_size_in;
         pc_ff        <= pc_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_dec_ff   <= s1_dec_in;
      s2_exe_ff   <= s2_exe_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The pc moves only when an item leaves the execute stage.
   a_pc_moves_on_exec : assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(pc_ff))
      else $error("pc changed without an item leaving the execute stage");

   // A faulting item leaves the pc where it was.
   a_fault_keeps_pc : assert property (@(posedge clock) disable iff (reset)
      s1_move && (exe.rsp.status != ST_OK) |-> exe.rsp.next_pc == pc_ff)
      else $error("faulting item moved the pc");

   // An accepted read never targets a register still waiting for writeback.
   a_no_read_over_write : assert property (@(posedge clock) disable iff (reset)
      accept && s2_valid_ff && s2_exe_ff.reg_we |->
         !(dec.rd_x && (dec.x_idx == s2_exe_ff.reg_widx)) &&
         !(dec.rd_y && (dec.y_idx == s2_exe_ff.reg_widx)))
      else $error("register read overtook a pending write");

   // A result never carries both a print byte and a sleep request.
   a_print_sleep_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.print_valid && rsp_data_ff.sleep_valid))
      else $error("print and sleep in one result");

endmodule

### tb/sv/bme_result_checker.sv
// Result checker for the byte machine instruction execute block.
// Watches the request, response and csr ports, predicts every result and compares it.
// Depends on bme_pkg for the item structs and the command, opcode and status codes.
module bme_result_checker
   import bme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    result_count,
   output int                    outstanding
);

   localparam int REG_DEPTH = 32;
   localparam int RAM_DEPTH = 512;

   // Shadow copy of the machine state and of the configuration.
   logic [7:0] reg_image [REG_DEPTH];
   logic [7:0] ram_image [RAM_DEPTH];
   logic [9:0] pc_image;
   logic [5:0] reg_count;
   logic [9:0] ram_bytes;

   // Results predicted at acceptance, oldest first.
   rsp_type predicted_results [$];

   // Executes one item on the shadow state and returns the result it must produce.
   function automatic rsp_type execute_item(input req_type item);
      rsp_type    res;
      int         reg_lim;
      int         ram_lim;
      int         a;
      int         b;
      int         c;
      int         addr;
      logic       use_b;
      logic       use_c;
      logic       fault;
      logic [7:0] va;
      logic [7:0] vb;
      logic [7:0] vc;
      logic [9:0] pc_after;
      reg_lim = (reg_count > REG_DEPTH) ? REG_DEPTH : int'(reg_count);
      ram_lim = (ram_bytes > RAM_DEPTH) ? RAM_DEPTH : int'(ram_bytes);
      a = item.operand_a;
      b = item.operand_b;
      c = item.operand_c;
      addr = item.load_address;
      res = '0;
      res.next_pc = pc_image;
      res.status = ST_OK;
      case (item.command)
         CMD_EXEC: begin
            // Every register index the opcode uses is checked before anything is read.
            use_c = (item.opcode <= OP_XOR);
            use_b = use_c || item.opcode == OP_LOAD || item.opcode == OP_STORE
                    || item.opcode == OP_JNE;
            if (item.opcode > OP_STOREI) begin
               res.status = ST_BAD_OP;
            end else if (a >= reg_lim || (use_b && b >= reg_lim) || (use_c && c >= reg_lim)) begin
               res.status = ST_RANGE;
            end
            if (res.status == ST_OK) begin
               va = reg_image[a];
               vb = use_b ? reg_image[b] : 8'd0;
               vc = use_c ? reg_image[c] : 8'd0;
               pc_after = pc_image + 10'd1;
               fault = 1'b0;
               case (item.opcode)
                  OP_AND: reg_image[a] = vb & vc;
                  OP_OR: reg_image[a] = vb | vc;
                  OP_ADD: reg_image[a] = vb + vc;
                  OP_MUL: reg_image[a] = vb * vc;
                  OP_XOR: reg_image[a] = vb ^ vc;
                  OP_PRINT: begin
                     res.print_valid = 1'b1;
                     res.print_byte = va;
                  end
                  OP_SLEEP: begin
                     res.sleep_valid = 1'b1;
                     res.sleep_seconds = va;
                  end
                  OP_LOAD: begin
                     if (vb >= ram_lim) fault = 1'b1;
                     else reg_image[a] = ram_image[vb];
                  end
                  OP_STORE: begin
                     if (vb >= ram_lim) fault = 1'b1;
                     else ram_image[vb] = va;
                  end
                  OP_JNE: begin
                     if (va != vb) pc_after = {2'b00, item.operand_c};
                  end
                  OP_LOADI: reg_image[a] = item.operand_b;
                  default: begin
                     // Immediate store through the address held in register a.
                     if (va >= ram_lim) fault = 1'b1;
                     else ram_image[va] = item.operand_b;
                  end
               endcase
               // A RAM address out of range leaves the pc where it was.
               if (fault) begin
                  res.status = ST_RANGE;
                  pc_after = pc_image;
               end
               pc_image = pc_after;
               res.next_pc = pc_after;
            end
         end
         CMD_LOAD_REG: begin
            if (addr < reg_lim) reg_image[addr] = item.load_data;
            else res.status = ST_RANGE;
         end
         CMD_LOAD_RAM: begin
            if (addr < ram_lim) ram_image[addr] = item.load_data;
            else res.status = ST_RANGE;
         end
         CMD_READ_REG: begin
            if (addr < reg_lim) res.read_data = reg_image[addr];
            else res.status = ST_RANGE;
         end
         CMD_READ_RAM: begin
            if (addr < ram_lim) res.read_data = ram_image[addr];
            else res.status = ST_RANGE;
         end
         default: res.status = ST_BAD_OP;
      endcase
      return res;
   endfunction

   // Reports one field that differs; the result counts toward the error total.
   function automatic int field_differs(input string field, input logic [9:0] want,
                                        input logic [9:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Compare results, follow configuration writes and predict accepted items.
   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      bad = 0;
      if (reset) begin
         pc_image = '0;
         reg_count = REG_COUNT_RESET;
         ram_bytes = RAM_SIZE_RESET;
         predicted_results.delete();
         error_count <= 0;
         result_count <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("response item arrived with no prediction pending");
               bad = 1;
            end else begin
               want = predicted_results.pop_front();
               bad += field_differs("next_pc", want.next_pc, rsp_data.next_pc);
               bad += field_differs("print_valid", want.print_valid, rsp_data.print_valid);
               bad += field_differs("print_byte", want.print_byte, rsp_data.print_byte);
               bad += field_differs("sleep_valid", want.sleep_valid, rsp_data.sleep_valid);
               bad += field_differs("sleep_seconds", want.sleep_seconds, rsp_data.sleep_seconds);
               bad += field_differs("read_data", want.read_data, rsp_data.read_data);
               bad += field_differs("status", want.status, rsp_data.status);
            end
            result_count <= result_count + 1;
         end
         if (csr_we) begin
            if (csr_index == CSR_REG_COUNT) reg_count = csr_wdata[5:0];
            else ram_bytes = csr_wdata;
         end
         if (req_valid && req_ready) begin
            predicted_results.push_back(execute_item(req_data));
         end
         error_count <= error_count + bad;
         outstanding <= predicted_results.size();
      end
   end

endmodule

### tb/sv/tb.sv
// Testbench top for the byte machine instruction execute block.
// Drives instruction and command items, sizes and stalls, and gives the verdict.
// Depends on bme_pkg, byte_machine_instruction_execute and bme_result_checker.
module tb;
   import bme_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int REG_DEPTH = 32;
   localparam int RAM_DEPTH = 512;
   localparam int HOLD_CYCLES = 80;

   // Codes outside the defined command and opcode sets.
   localparam logic [2:0] CMD_UNDEF_LOW  = 3'd5;
   localparam logic [2:0] CMD_UNDEF_HIGH = 3'd7;
   localparam logic [7:0] OP_UNDEF_LOW   = 8'd12;
   localparam logic [7:0] OP_UNDEF_HIGH  = 8'd255;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [0:0]            csr_index = CSR_REG_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int result_count;
   int outstanding;

   // Traffic shaping and the sizes that the stimulus currently aims at.
   int send_idle_pct = 0;
   int ready_idle_pct = 0;
   bit stall_request = 1'b0;
   int items_sent = 0;
   int reg_limit = REG_DEPTH;
   int ram_limit = RAM_DEPTH;

   byte_machine_instruction_execute u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bme_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .result_count (result_count),
      .outstanding  (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop if the block hangs.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      int hold_left;
      bit stall_done;
      hold_left = 0;
      stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request && !stall_done) begin
            hold_left = HOLD_CYCLES;
            stall_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
         end
      end
   end

   // Builds an execute item; the load fields are unused and get random bits.
   function automatic req_type exec_item(input logic [7:0] opcode, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
      req_type item;
      item.command = CMD_EXEC;
      item.opcode = opcode;
      item.operand_a = a;
      item.operand_b = b;
      item.operand_c = c;
      item.load_address = 9'($urandom_range(0, 511));
      item.load_data = 8'($urandom);
      return item;
   endfunction

   // Builds a load, read or unknown command item; the instruction bytes are random.
   function automatic req_type port_item(input logic [2:0] command, input logic [8:0] addr,
                                         input logic [7:0] data);
      req_type item;
      item = exec_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      item.command = command;
      item.load_address = addr;
      item.load_data = data;
      return item;
   endfunction

   function automatic logic [7:0] pick_reg();
      if (reg_limit > 0) return 8'($urandom_range(0, reg_limit - 1));
      return 8'($urandom);
   endfunction

   // A RAM address that fits in a register byte and is in range when possible.
   function automatic logic [7:0] pick_ram_byte();
      if (ram_limit > 0) return 8'($urandom_range(0, (ram_limit > 256 ? 256 : ram_limit) - 1));
      return 8'($urandom);
   endfunction

   // Address for a load or read command: mostly in range, sometimes anything.
   function automatic logic [8:0] pick_port_addr(input logic [2:0] command);
      int lim;
      lim = (command == CMD_LOAD_RAM || command == CMD_READ_RAM) ? ram_limit : reg_limit;
      if (lim == 0 || $urandom_range(0, 4) == 0) return 9'($urandom);
      return 9'($urandom_range(0, lim - 1));
   endfunction

   // Offers one item after a random gap and returns at the edge that accepts it.
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Holds the request side off until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (result_count != items_sent || outstanding != 0) @(posedge clock);
   endtask

   // Writes both sizes while the block is idle.
   task automatic configure(input int regs, input int bytes);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_REG_COUNT;
      csr_wdata <= CSR_DATA_W'(regs);
      @(posedge clock);
      csr_index <= CSR_RAM_SIZE;
      csr_wdata <= CSR_DATA_W'(bytes);
      @(posedge clock);
      csr_we <= 1'b0;
      reg_limit = regs > REG_DEPTH ? REG_DEPTH : regs;
      ram_limit = bytes > RAM_DEPTH ? RAM_DEPTH : bytes;
   endtask

   // One random slot: plain instructions, pointer-then-memory pairs, port
   // commands, or fully random noise.
   task automatic random_slot();
      int         choice;
      logic [7:0] op;
      logic [7:0] ptr;
      logic [2:0] command;
      req_type    item;
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
         op = 8'($urandom_range(OP_AND, OP_LOADI));
         if (op == OP_LOADI) send_item(exec_item(op, pick_reg(), 8'($urandom), pick_reg()));
         else if (op == OP_JNE) send_item(exec_item(op, pick_reg(), pick_reg(), 8'($urandom)));
         else send_item(exec_item(op, pick_reg(), pick_reg(), pick_reg()));
      end else if (choice < 65) begin
         // Point a register at a RAM byte, then go through it.
         ptr = pick_reg();
         send_item(exec_item(OP_LOADI, ptr, pick_ram_byte(), pick_reg()));
         case ($urandom_range(0, 2))
            0: send_item(exec_item(OP_LOAD, pick_reg(), ptr, pick_reg()));
            1: send_item(exec_item(OP_STORE, pick_reg(), ptr, pick_reg()));
            default: send_item(exec_item(OP_STOREI, ptr, 8'($urandom), pick_reg()));
         endcase
      end else if (choice < 80) begin
         command = 3'($urandom_range(CMD_LOAD_REG, CMD_READ_RAM));
         send_item(port_item(command, pick_port_addr(command), 8'($urandom)));
      end else begin
         item = exec_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         item.command = 3'($urandom_range(0, 7));
         send_item(item);
      end
   endtask

   // Reset, stimulus phases and verdict.
   initial begin
      int         slot;
      logic [7:0] op;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 37;
      ready_idle_pct = 69;
      configure(REG_DEPTH, RAM_DEPTH);

      // Fill every register and RAM byte so no later read finds an unwritten entry.
      for (slot = 0; slot < REG_DEPTH; slot++) begin
         send_item(port_item(CMD_LOAD_REG, 9'(slot), 8'($urandom)));
      end
      for (slot = 0; slot < RAM_DEPTH; slot++) begin
         send_item(port_item(CMD_LOAD_RAM, 9'(slot), 8'($urandom)));
      end

      // Directed: every opcode, wrapping arithmetic, jumps, unknown codes, range faults.
      send_item(exec_item(OP_LOADI, 8'd0, 8'd255, 8'd0));
      send_item(exec_item(OP_LOADI, 8'd1, 8'd0, 8'd0));
      send_item(exec_item(OP_LOADI, 8'd31, 8'd128, 8'd0));
      send_item(exec_item(OP_ADD, 8'd2, 8'd0, 8'd0));
      send_item(exec_item(OP_MUL, 8'd3, 8'd0, 8'd31));
      send_item(exec_item(OP_AND, 8'd4, 8'd0, 8'd31));
      send_item(exec_item(OP_OR, 8'd5, 8'd1, 8'd31));
      send_item(exec_item(OP_XOR, 8'd6, 8'd0, 8'd31));
      send_item(exec_item(OP_PRINT, 8'd0, 8'd0, 8'd0));
      send_item(exec_item(OP_SLEEP, 8'd31, 8'd0, 8'd0));
      send_item(exec_item(OP_STOREI, 8'd0, 8'hA5, 8'd0));
      send_item(exec_item(OP_LOAD, 8'd7, 8'd0, 8'd0));
      send_item(exec_item(OP_STORE, 8'd6, 8'd31, 8'd0));
      send_item(exec_item(OP_JNE, 8'd0, 8'd1, 8'd255));
      send_item(exec_item(OP_JNE, 8'd0, 8'd0, 8'd0));
      send_item(exec_item(OP_UNDEF_LOW, 8'd0, 8'd0, 8'd0));
      send_item(exec_item(OP_UNDEF_HIGH, 8'd0, 8'd0, 8'd0));
      send_item(exec_item(OP_ADD, 8'd0, 8'd0, 8'd255));
      send_item(exec_item(OP_PRINT, 8'd32, 8'd0, 8'd0));
      send_item(port_item(CMD_LOAD_REG, 9'd32, 8'd1));
      send_item(port_item(CMD_LOAD_RAM, 9'd511, 8'd255));
      send_item(port_item(CMD_READ_RAM, 9'd511, 8'd0));
      send_item(port_item(CMD_READ_REG, 9'd31, 8'd0));
      send_item(port_item(CMD_READ_REG, 9'd511, 8'd0));
      send_item(port_item(CMD_UNDEF_LOW, 9'd0, 8'd0));
      send_item(port_item(CMD_UNDEF_HIGH, 9'd511, 8'd255));

      // Random traffic under several sizes; stored bytes must survive each change.
      repeat (150) random_slot();
      configure(5, 40);
      repeat (100) random_slot();
      send_idle_pct = 69;
      ready_idle_pct = 37;
      configure(0, 0);
      repeat (40) random_slot();
      configure(REG_DEPTH, 1);
      repeat (80) random_slot();
      configure(1, RAM_DEPTH);
      repeat (60) random_slot();

      // No idling: a long hold-off on the response side fills the pipeline, and a
      // straight run from pc 255 with no jumps carries the pc across its wrap.
      send_idle_pct = 0;
      ready_idle_pct = 0;
      configure(REG_DEPTH, RAM_DEPTH);
      stall_request = 1'b1;
      send_item(exec_item(OP_LOADI, 8'd0, 8'd1, 8'd0));
      send_item(exec_item(OP_LOADI, 8'd1, 8'd2, 8'd0));
      send_item(exec_item(OP_JNE, 8'd0, 8'd1, 8'd255));
      repeat (780) begin
         op = 8'($urandom_range(0, 7));
         if (op == OP_LOAD) op = OP_LOADI;
         send_item(exec_item(op, 8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                             8'($urandom_range(0, 31))));
      end
      drain();
      repeat (150) random_slot();

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
